// ===== design/rrqs_pkg.sv =====
// Shared types and constants for the round-robin quantum scheduler.
// No dependencies; rrqs_flags and the scheduler import this package.
package rrqs_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int COUNT_W   = $clog2(MAX_SLOTS + 1);
  localparam int PID_W     = 16;
  localparam int BURST_W   = 15;
  localparam int DATA_W    = PID_W + BURST_W;
  localparam int LINK_W    = 2 * SLOT_W;

  localparam logic [COUNT_W-1:0] SLOT_LIMIT = COUNT_W'(MAX_SLOTS);

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_FULL  = 2'd1;
  localparam logic [1:0] CMD_PART  = 2'd2;
  localparam logic [1:0] CMD_CLRIO = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic CFG_MAX_PROC = 1'b0;
  localparam logic CFG_QUANTUM  = 1'b1;

  localparam logic [2:0] FLAG_NONE   = 3'd0;
  localparam logic [2:0] FLAG_ALLOC  = 3'd1;
  localparam logic [2:0] FLAG_FREE   = 3'd2;
  localparam logic [2:0] FLAG_IO_SET = 3'd3;
  localparam logic [2:0] FLAG_IO_CLR = 3'd4;

  // Link word layout: next slot in the upper half, previous slot in the lower.
  localparam logic [LINK_W-1:0] LINK_NEXT_MASK = {{SLOT_W{1'b1}}, {SLOT_W{1'b0}}};
  localparam logic [LINK_W-1:0] LINK_PREV_MASK = {{SLOT_W{1'b0}}, {SLOT_W{1'b1}}};
  localparam logic [LINK_W-1:0] LINK_ALL_MASK  = {LINK_W{1'b1}};

  typedef struct packed {
    logic [1:0]         cmd;
    logic [PID_W-1:0]   new_pid;
    logic [BURST_W-1:0] new_burst;
    logic [BURST_W-1:0] partial_time;
    logic [SLOT_W-1:0]  io_slot;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot;
    logic [PID_W-1:0]   current_pid;
    logic [BURST_W-1:0] current_burst;
    logic               current_in_io;
    logic               finished;
    logic [PID_W-1:0]   finished_pid;
    logic [COUNT_W-1:0] process_count;
  } rsp_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [SLOT_W-1:0] idx;
  } flag_cmd_t;

endpackage

// ===== design/rrqs_ram.sv =====
// Generic synchronous RAM with one bit-masked write port and one read port.
// Read data is registered. No dependencies.
module rrqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [WIDTH-1:0]         wmask,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wmask[i]) begin
          mem[waddr][i] <= wdata[i];
        end
      end
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/rrqs_flags.sv =====
// Per-slot valid and I/O flags with the lowest-free-slot finder.
// Depends on rrqs_pkg.
module rrqs_flags import rrqs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  flag_cmd_t             cmd,
  output logic [MAX_SLOTS-1:0]  slot_valid,
  output logic [MAX_SLOTS-1:0]  slot_io,
  output logic [SLOT_W-1:0]     free_idx,
  output logic                  free_any
);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_io    <= '0;
    end else begin
      unique case (cmd.op)
        FLAG_ALLOC: begin
          slot_valid[cmd.idx] <= 1'b1;
          slot_io[cmd.idx]    <= 1'b0;
        end
        FLAG_FREE: begin
          slot_valid[cmd.idx] <= 1'b0;
          slot_io[cmd.idx]    <= 1'b0;
        end
        FLAG_IO_SET: slot_io[cmd.idx] <= 1'b1;
        FLAG_IO_CLR: slot_io[cmd.idx] <= 1'b0;
        default: ;
      endcase
    end
  end

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_idx = SLOT_W'(i);
        free_any = 1'b1;
      end
    end
  end

endmodule

// ===== design/round_robin_quantum_scheduler.sv =====
// Round-robin time-slice scheduler over a ring of sixteen process slots.
// Depends on rrqs_pkg, rrqs_ram and rrqs_flags.

// Process ids and bursts live in one RAM and the ring's next/previous links
// in a second RAM, both with one write port and a registered read; valid and
// I/O flags are flip-flops. One request is handled at a time and returns one
// response, and the next request is accepted once that response is loaded.
// The single write port of the link RAM splices one link per cycle, so an add
// into a non-empty ring writes links in S_ADD_L, S_ADD_P and S_ADD_N, and a
// run that removes a process other than the last writes the second link in
// S_REM_P. Every request but a run on an empty ring reads the current slot in
// S_RDCUR for the response. The next request is taken while a response still
// waits on the output; a response that is still held then delays the one after.
module round_robin_quantum_scheduler import rrqs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ADD_L = 4'd1;
  localparam logic [3:0] S_ADD_P = 4'd2;
  localparam logic [3:0] S_ADD_N = 4'd3;
  localparam logic [3:0] S_SKIP  = 4'd4;
  localparam logic [3:0] S_EXEC  = 4'd5;
  localparam logic [3:0] S_REM_P = 4'd6;
  localparam logic [3:0] S_RDCUR = 4'd7;
  localparam logic [3:0] S_CAP   = 4'd8;

  logic [3:0]         state, state_next;
  logic [SLOT_W-1:0]  cur, cur_next;
  logic [SLOT_W-1:0]  tail, tail_next;
  logic [COUNT_W-1:0] live, live_next;
  logic [COUNT_W-1:0] maxp;
  logic [BURST_W-1:0] quant;
  logic               rsp_valid_next;

  req_t               req_q;
  logic [SLOT_W-1:0]  n_slot, n_slot_next;
  logic [SLOT_W-1:0]  h_slot, h_slot_next;
  logic [SLOT_W-1:0]  nx_slot, nx_slot_next;
  logic [SLOT_W-1:0]  pv_slot, pv_slot_next;
  logic [1:0]         st, st_next;
  logic               added, added_next;
  logic               fin, fin_next;
  logic [PID_W-1:0]   fin_pid, fin_pid_next;
  logic               rsp_load;

  logic               d_we, d_re;
  logic [SLOT_W-1:0]  d_waddr, d_raddr;
  logic [DATA_W-1:0]  d_wdata, d_rdata;
  logic               l_we, l_re;
  logic [SLOT_W-1:0]  l_waddr, l_raddr;
  logic [LINK_W-1:0]  l_wdata, l_wmask, l_rdata;

  flag_cmd_t              fcmd;
  logic [MAX_SLOTS-1:0]   slot_valid;
  logic [MAX_SLOTS-1:0]   slot_io;
  logic [SLOT_W-1:0]      free_idx;
  logic                   free_any;

  logic [PID_W-1:0]   rd_pid;
  logic [BURST_W-1:0] rd_burst;
  logic [SLOT_W-1:0]  rd_next, rd_prev;
  logic [COUNT_W-1:0] limit;
  logic [BURST_W-1:0] burst_left;

  rrqs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SLOTS)) u_data_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .wmask ({DATA_W{1'b1}}),
    .re    (d_re),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  rrqs_ram #(.WIDTH(LINK_W), .DEPTH(MAX_SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .wmask (l_wmask),
    .re    (l_re),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  rrqs_flags u_flags (
    .clk        (clk),
    .rst        (rst),
    .cmd        (fcmd),
    .slot_valid (slot_valid),
    .slot_io    (slot_io),
    .free_idx   (free_idx),
    .free_any   (free_any)
  );

  assign rd_pid     = d_rdata[DATA_W-1 -: PID_W];
  assign rd_burst   = d_rdata[BURST_W-1:0];
  assign rd_next    = l_rdata[LINK_W-1 -: SLOT_W];
  assign rd_prev    = l_rdata[SLOT_W-1:0];
  assign limit      = (maxp > SLOT_LIMIT) ? SLOT_LIMIT : maxp;
  assign burst_left = rd_burst - quant;
  assign req_stall  = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign rsp_load   = (state == S_CAP) && (!rsp_valid || !rsp_stall);

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    tail_next      = tail;
    live_next      = live;
    n_slot_next    = n_slot;
    h_slot_next    = h_slot;
    nx_slot_next   = nx_slot;
    pv_slot_next   = pv_slot;
    st_next        = st;
    added_next     = added;
    fin_next       = fin;
    fin_pid_next   = fin_pid;
    rsp_valid_next = rsp_valid && rsp_stall;
    d_we           = 1'b0;
    d_waddr        = cur;
    d_wdata        = d_rdata;
    d_re           = 1'b0;
    d_raddr        = cur;
    l_we           = 1'b0;
    l_waddr        = cur;
    l_wdata        = '0;
    l_wmask        = LINK_ALL_MASK;
    l_re           = 1'b0;
    l_raddr        = cur;
    fcmd.op        = FLAG_NONE;
    fcmd.idx       = cur;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          st_next      = ST_OK;
          added_next   = 1'b0;
          fin_next     = 1'b0;
          fin_pid_next = '0;
          case (req.cmd)
            CMD_ADD: begin
              if (live >= limit || !free_any) begin
                st_next    = ST_FULL;
                state_next = S_RDCUR;
              end else begin
                d_we        = 1'b1;
                d_waddr     = free_idx;
                d_wdata     = {req.new_pid, req.new_burst};
                fcmd.op     = FLAG_ALLOC;
                fcmd.idx    = free_idx;
                n_slot_next = free_idx;
                added_next  = 1'b1;
                if (live == '0) begin
                  l_we       = 1'b1;
                  l_waddr    = free_idx;
                  l_wdata    = {free_idx, free_idx};
                  cur_next   = free_idx;
                  tail_next  = free_idx;
                  live_next  = live + 1'b1;
                  state_next = S_RDCUR;
                end else begin
                  l_re       = 1'b1;
                  l_raddr    = tail;
                  state_next = S_ADD_L;
                end
              end
            end
            CMD_FULL, CMD_PART: begin
              if (live == '0) begin
                st_next    = ST_EMPTY;
                state_next = S_CAP;
              end else if (slot_io[cur]) begin
                l_re       = 1'b1;
                state_next = S_SKIP;
              end else begin
                l_re       = 1'b1;
                d_re       = 1'b1;
                state_next = S_EXEC;
              end
            end
            default: begin
              fcmd.op    = FLAG_IO_CLR;
              fcmd.idx   = req.io_slot;
              state_next = S_RDCUR;
            end
          endcase
        end
      end
      S_ADD_L: begin
        l_we        = 1'b1;
        l_waddr     = n_slot;
        l_wdata     = {rd_next, tail};
        h_slot_next = rd_next;
        state_next  = S_ADD_P;
      end
      S_ADD_P: begin
        l_we       = 1'b1;
        l_waddr    = h_slot;
        l_wdata    = {n_slot, n_slot};
        l_wmask    = LINK_PREV_MASK;
        state_next = S_ADD_N;
      end
      S_ADD_N: begin
        l_we       = 1'b1;
        l_waddr    = tail;
        l_wdata    = {n_slot, n_slot};
        l_wmask    = LINK_NEXT_MASK;
        tail_next  = n_slot;
        live_next  = live + 1'b1;
        state_next = S_RDCUR;
      end
      S_SKIP: begin
        cur_next   = rd_next;
        state_next = S_RDCUR;
      end
      S_EXEC: begin
        nx_slot_next = rd_next;
        pv_slot_next = rd_prev;
        state_next   = S_RDCUR;
        if (req_q.cmd == CMD_FULL) begin
          if (rd_burst >= quant && burst_left != '0) begin
            d_we     = 1'b1;
            d_wdata  = {rd_pid, burst_left};
            cur_next = rd_next;
          end else begin
            fin_next     = 1'b1;
            fin_pid_next = rd_pid;
            fcmd.op      = FLAG_FREE;
            live_next    = live - 1'b1;
            if (live == COUNT_W'(1)) begin
              cur_next  = '0;
              tail_next = '0;
            end else begin
              if (tail == cur) begin
                tail_next = rd_prev;
              end
              cur_next   = rd_next;
              l_we       = 1'b1;
              l_waddr    = rd_prev;
              l_wdata    = {rd_next, rd_next};
              l_wmask    = LINK_NEXT_MASK;
              state_next = S_REM_P;
            end
          end
        end else begin
          if (req_q.partial_time >= rd_burst || req_q.partial_time >= quant) begin
            st_next = ST_RANGE;
          end else begin
            if (rd_burst >= quant) begin
              fcmd.op = FLAG_IO_SET;
            end
            d_we    = 1'b1;
            d_wdata = {rd_pid, rd_burst - req_q.partial_time};
          end
        end
      end
      S_REM_P: begin
        l_we       = 1'b1;
        l_waddr    = nx_slot;
        l_wdata    = {pv_slot, pv_slot};
        l_wmask    = LINK_PREV_MASK;
        state_next = S_RDCUR;
      end
      S_RDCUR: begin
        d_re       = 1'b1;
        state_next = S_CAP;
      end
      S_CAP: begin
        if (rsp_load) begin
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur       <= '0;
      tail      <= '0;
      live      <= '0;
      maxp      <= COUNT_W'(MAX_SLOTS);
      quant     <= BURST_W'(4);
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur       <= cur_next;
      tail      <= tail_next;
      live      <= live_next;
      rsp_valid <= rsp_valid_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MAX_PROC: maxp  <= cfg_data[COUNT_W-1:0];
          CFG_QUANTUM:  quant <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      req_q <= req;
    end
    n_slot  <= n_slot_next;
    h_slot  <= h_slot_next;
    nx_slot <= nx_slot_next;
    pv_slot <= pv_slot_next;
    st      <= st_next;
    added   <= added_next;
    fin     <= fin_next;
    fin_pid <= fin_pid_next;
    if (rsp_load) begin
      rsp.status        <= st;
      rsp.slot          <= added ? n_slot : cur;
      rsp.current_pid   <= (live != '0) ? rd_pid : '0;
      rsp.current_burst <= (live != '0) ? rd_burst : '0;
      rsp.current_in_io <= (live != '0) && slot_io[cur];
      rsp.finished      <= fin;
      rsp.finished_pid  <= fin_pid;
      rsp.process_count <= live;
    end
  end

  assert property (@(posedge clk) disable iff (rst) live <= SLOT_LIMIT)
    else $error("Process count exceeds the number of slots.");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(slot_valid) == int'(live)))
    else $error("Valid slot flags disagree with the process count.");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && live == '0) |-> (cur == '0 && tail == '0))
    else $error("Empty ring does not have current and tail at slot zero.");

endmodule
